// ----- rtl/vtsi_pkg.sv -----
// Package for the velocity time-sync interpolation core.
// Holds status codes, register map and fixed field widths; no dependencies.
package vtsi_pkg;

  localparam int AXES   = 6;
  localparam int TIME_W = 32;
  localparam int STAT_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_SYNCED   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_FEW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_RDY  = 2'd2;

  // Input item kinds.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_SYNC = 1'b1;

  // Register index of max_gap (byte address divided by four).
  localparam logic [ADDR_W-3:0] REG_MAX_GAP = '0;
  localparam logic [DATA_W-1:0] MAX_GAP_RESET = 32'd200000;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOOP = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_FIN  = 9'b000001000,
    S_FRD  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_RND  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage

// ----- rtl/velocity_time_sync_interp_core.sv -----
// Top level of the velocity time-sync interpolation core.
// Uses vtsi_pkg for codes and widths; holds the sample ring memories.

// A push item is taken straight from the idle state. A sync request visits a
// ring read state and a check state per pruning step, then S_FIN and S_FRD to read
// the final pair, and, when the pair must be blended, for each of the six axes a
// multiply state, one quotient bit per cycle of the shared restoring divider
// (VELOCITY_WIDTH+32 bits) and a rounding state. Results leave through an
// output register.
module velocity_time_sync_interp_core #(
  parameter int BUFFER_DEPTH   = 16,
  parameter int VELOCITY_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic [vtsi_pkg::TIME_W-1:0]           time_stamp,
  input  logic signed [VELOCITY_WIDTH-1:0]      lin_x,
  input  logic signed [VELOCITY_WIDTH-1:0]      lin_y,
  input  logic signed [VELOCITY_WIDTH-1:0]      lin_z,
  input  logic signed [VELOCITY_WIDTH-1:0]      ang_x,
  input  logic signed [VELOCITY_WIDTH-1:0]      ang_y,
  input  logic signed [VELOCITY_WIDTH-1:0]      ang_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [vtsi_pkg::STAT_W-1:0]           status,
  output logic [vtsi_pkg::TIME_W-1:0]           out_time,
  output logic signed [VELOCITY_WIDTH-1:0]      out_lin_x,
  output logic signed [VELOCITY_WIDTH-1:0]      out_lin_y,
  output logic signed [VELOCITY_WIDTH-1:0]      out_lin_z,
  output logic signed [VELOCITY_WIDTH-1:0]      out_ang_x,
  output logic signed [VELOCITY_WIDTH-1:0]      out_ang_y,
  output logic signed [VELOCITY_WIDTH-1:0]      out_ang_z,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vtsi_pkg::ADDR_W-1:0]           paddr,
  input  logic [vtsi_pkg::DATA_W-1:0]           pwdata,
  output logic [vtsi_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import vtsi_pkg::*;

  localparam int VW  = VELOCITY_WIDTH;
  localparam int IW  = $clog2(BUFFER_DEPTH);
  localparam int FW  = $clog2(BUFFER_DEPTH + 1);
  localparam int SW  = FW + 1;
  localparam int PW  = VW + TIME_W;
  localparam int CW  = $clog2(PW);
  localparam int EW  = AXES * VW;
  localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(PW - 1);
  localparam logic [2:0]    LAST_AXIS = 3'(AXES - 1);

  // Ring position k places after the head.
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] hd, input logic [FW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(hd) + SW'(k);
    if (sum >= SW'(BUFFER_DEPTH)) begin
      sum = sum - SW'(BUFFER_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  state_t state;
  logic [DATA_W-1:0] max_gap;
  logic [IW-1:0] head;
  logic [FW-1:0] fill;
  logic [TIME_W-1:0] t_req;

  // Sample ring memories, two read ports each, registered read data.
  logic [TIME_W-1:0] time_mem [BUFFER_DEPTH];
  logic [EW-1:0]     vel_mem  [BUFFER_DEPTH];
  logic [TIME_W-1:0] tf, tb;
  logic [EW-1:0]     vf, vb;
  logic [IW-1:0]     ra0, ra1, wa;
  logic              push;

  assign ra0  = head;
  assign ra1  = slot(head, FW'(1));
  assign wa   = slot(head, fill);
  assign push = in_valid && in_ready && (kind == KIND_PUSH);

  always_ff @(posedge clk) begin
    if (push) begin
      time_mem[wa] <= time_stamp;
      vel_mem[wa]  <= {ang_z, ang_y, ang_x, lin_z, lin_y, lin_x};
    end
    tf <= time_mem[ra0];
    tb <= time_mem[ra1];
    vf <= vel_mem[ra0];
    vb <= vel_mem[ra1];
  end

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_MAX_GAP) ? max_gap : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= MAX_GAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_MAX_GAP) begin
      max_gap <= pwdata;
    end
  end

  // Blend datapath registers.
  logic              neg_t;
  logic [TIME_W-1:0] mt, md;
  logic [2:0]        axis;
  logic [CW-1:0]     bitc;
  logic [PW-1:0]     prod;
  logic [TIME_W-1:0] rem;
  logic [STAT_W-1:0] res_status;
  logic signed [VW-1:0] res_v [AXES];

  // Time differences of the final pair.
  logic signed [TIME_W:0] num_d, den_d;
  assign num_d = $signed({1'b0, t_req}) - $signed({1'b0, tf});
  assign den_d = $signed({1'b0, tb}) - $signed({1'b0, tf});

  // Current axis velocity difference and its magnitude.
  logic signed [VW-1:0] f_ax, b_ax;
  logic signed [VW:0]   dv;
  logic [VW-1:0]        mv;
  assign f_ax = vf[axis*VW +: VW];
  assign b_ax = vb[axis*VW +: VW];
  assign dv   = {b_ax[VW-1], b_ax} - {f_ax[VW-1], f_ax};
  assign mv   = dv[VW] ? VW'(-dv) : dv[VW-1:0];

  // One restoring division step.
  logic [TIME_W:0] sh;
  logic            ge;
  assign sh = {rem, prod[PW-1]};
  assign ge = sh >= {1'b0, md};

  // Rounding and saturation of one axis.
  logic              rnd, big, neg;
  logic [VW:0]       qs;
  logic signed [VW+1:0] res;
  logic signed [VW-1:0] sat;
  localparam logic signed [VW+1:0] HI = (VW+2)'((1 << (VW - 1)) - 1);
  localparam logic signed [VW+1:0] LO = -HI - (VW+2)'(1);
  always_comb begin
    neg = neg_t ^ dv[VW];
    rnd = {rem, 1'b0} >= {1'b0, md};
    big = (prod >> VW) != '0;
    qs  = {1'b0, prod[VW-1:0]} + (VW+1)'(rnd);
    if (neg) begin
      res = (VW+2)'(f_ax) - $signed({1'b0, qs});
    end else begin
      res = (VW+2)'(f_ax) + $signed({1'b0, qs});
    end
    if (big) begin
      sat = neg ? LO[VW-1:0] : HI[VW-1:0];
    end else if (res > HI) begin
      sat = HI[VW-1:0];
    end else if (res < LO) begin
      sat = LO[VW-1:0];
    end else begin
      sat = res[VW-1:0];
    end
  end

  assign in_ready = (state == S_IDLE);

  // A finished result moves to the output register once that register is free.
  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      fill  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (kind == KIND_PUSH) begin
              if (fill == DEPTH_F) begin
                head <= slot(head, FW'(1));
              end else begin
                fill <= fill + FW'(1);
              end
            end else begin
              t_req <= time_stamp;
              res_status <= STAT_SYNCED;
              for (int a = 0; a < AXES; a++) begin
                res_v[a] <= '0;
              end
              state <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          if (fill < FW'(2)) begin
            res_status <= STAT_TOO_FEW;
            state <= S_DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (tf > t_req) begin
            res_status <= STAT_NOT_RDY;
            state <= S_DONE;
          end else if (tb < t_req) begin
            head <= ra1;
            fill <= fill - FW'(1);
            state <= S_LOOP;
          end else begin
            if ((t_req - tf) > max_gap || (tb - t_req) > max_gap) begin
              head <= ra1;
              fill <= fill - FW'(1);
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fill < FW'(2)) begin
            res_status <= STAT_TOO_FEW;
            state <= S_DONE;
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          if (den_d == '0) begin
            for (int a = 0; a < AXES; a++) begin
              res_v[a] <= vf[a*VW +: VW];
            end
            state <= S_DONE;
          end else begin
            neg_t <= num_d[TIME_W] ^ den_d[TIME_W];
            mt <= num_d[TIME_W] ? TIME_W'(-num_d) : num_d[TIME_W-1:0];
            md <= den_d[TIME_W] ? TIME_W'(-den_d) : den_d[TIME_W-1:0];
            axis <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= PW'(mv) * PW'(mt);
          rem  <= '0;
          bitc <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? TIME_W'(sh - {1'b0, md}) : sh[TIME_W-1:0];
          prod <= {prod[PW-2:0], ge};
          bitc <= bitc + CW'(1);
          if (bitc == LAST_BIT) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          res_v[axis] <= sat;
          if (axis == LAST_AXIS) begin
            state <= S_DONE;
          end else begin
            axis <= axis + 3'd1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register, loaded when the result is handed over.
  logic signed [VW-1:0] out_v [AXES];
  always_ff @(posedge clk) begin
    if (load_out) begin
      status   <= res_status;
      out_time <= t_req;
      for (int a = 0; a < AXES; a++) begin
        out_v[a] <= res_v[a];
      end
    end
  end

  assign out_lin_x = out_v[0];
  assign out_lin_y = out_v[1];
  assign out_lin_z = out_v[2];
  assign out_ang_x = out_v[3];
  assign out_ang_y = out_v[4];
  assign out_ang_z = out_v[5];

endmodule

// ----- tb/vtsi_checker.sv -----
// Checker for the velocity time-sync interpolation core: watches both item
// channels and the register port, predicts each result and compares it.
// Depends on vtsi_pkg for status codes, widths and the register map.
module vtsi_checker #(
  parameter int DEPTH = 16,
  parameter int VW    = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         kind,
  input  logic [vtsi_pkg::TIME_W-1:0]  time_stamp,
  input  logic signed [VW-1:0]         lin_x,
  input  logic signed [VW-1:0]         lin_y,
  input  logic signed [VW-1:0]         lin_z,
  input  logic signed [VW-1:0]         ang_x,
  input  logic signed [VW-1:0]         ang_y,
  input  logic signed [VW-1:0]         ang_z,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [vtsi_pkg::STAT_W-1:0]  status,
  input  logic [vtsi_pkg::TIME_W-1:0]  out_time,
  input  logic signed [VW-1:0]         out_lin_x,
  input  logic signed [VW-1:0]         out_lin_y,
  input  logic signed [VW-1:0]         out_lin_z,
  input  logic signed [VW-1:0]         out_ang_x,
  input  logic signed [VW-1:0]         out_ang_y,
  input  logic signed [VW-1:0]         out_ang_z,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vtsi_pkg::ADDR_W-1:0]  paddr,
  input  logic [vtsi_pkg::DATA_W-1:0]  pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending,
  output int                           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import vtsi_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]        stat;
    logic [TIME_W-1:0]        t;
    logic [AXES-1:0][VW-1:0]  vel;
  } sync_result_t;

  // Shadow copy of the ring and the register.
  logic [31:0]              gap_limit;
  logic [TIME_W-1:0]        ring_time [DEPTH];
  logic [AXES-1:0][VW-1:0]  ring_vel [DEPTH];
  int                       head;
  int                       fill;
  sync_result_t             expected_q[$];

  function automatic int ring_slot(int k);
    return (head + k) % DEPTH;
  endfunction

  // Linear blend of one axis, rounded half away from zero, then saturated.
  function automatic logic [VW-1:0] blend_axis(longint f, longint b, longint num,
                                               longint den);
    longint   dv;
    bit       neg;
    bit [63:0] mv, mt, md, prod, q, r;
    longint   res, hi, lo;
    dv = b - f;
    neg = 0;
    if (dv < 0) begin neg = !neg; mv = -dv; end else mv = dv;
    if (num < 0) begin neg = !neg; mt = -num; end else mt = num;
    if (den < 0) begin neg = !neg; md = -den; end else md = den;
    prod = mv * mt;
    q = prod / md;
    r = prod % md;
    if (r >= md - r) q++;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    res = neg ? f - longint'(q) : f + longint'(q);
    hi = (longint'(1) <<< (VW - 1)) - 1;
    lo = -hi - 1;
    if (res > hi) res = hi;
    if (res < lo) res = lo;
    return res[VW-1:0];
  endfunction

  // Apply one accepted item to the shadow ring; a sync request queues a result.
  task automatic predict_item(logic k, logic [TIME_W-1:0] t,
                              logic [AXES-1:0][VW-1:0] v);
    sync_result_t res;
    logic [TIME_W-1:0] tf, tb;
    longint num, den;
    int sf, sb;
    if (k == KIND_PUSH) begin
      if (fill >= DEPTH) begin
        head = ring_slot(1);
        fill--;
      end
      ring_time[ring_slot(fill)] = t;
      ring_vel[ring_slot(fill)] = v;
      fill++;
      return;
    end
    res.stat = STAT_SYNCED;
    res.t = t;
    res.vel = '0;
    // Prune the front of the ring.
    while (fill >= 2) begin
      tf = ring_time[ring_slot(0)];
      tb = ring_time[ring_slot(1)];
      if (tf > t) begin
        res.stat = STAT_NOT_RDY;
        expected_q = {expected_q, res};
        return;
      end
      if (tb < t) begin
        head = ring_slot(1);
        fill--;
        continue;
      end
      if ((t - tf) > gap_limit || (tb - t) > gap_limit) begin
        head = ring_slot(1);
        fill--;
      end
      break;
    end
    if (fill < 2) begin
      res.stat = STAT_TOO_FEW;
      expected_q = {expected_q, res};
      return;
    end
    sf = ring_slot(0);
    sb = ring_slot(1);
    num = longint'({1'b0, t}) - longint'({1'b0, ring_time[sf]});
    den = longint'({1'b0, ring_time[sb]}) - longint'({1'b0, ring_time[sf]});
    for (int a = 0; a < AXES; a++) begin
      if (den == 0) res.vel[a] = ring_vel[sf][a];
      else res.vel[a] = blend_axis(longint'($signed(ring_vel[sf][a])),
                                   longint'($signed(ring_vel[sb][a])), num, den);
    end
    expected_q = {expected_q, res};
  endtask

  task automatic report_mismatch(string field, logic [63:0] exp_v, logic [63:0] got_v);
    $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field, exp_v, got_v);
    fail_count++;
  endtask

  // Sample all three ports at each rising edge.
  always @(posedge clk) begin
    sync_result_t exp_r;
    logic [AXES-1:0][VW-1:0] got_vel;
    if (rst) begin
      gap_limit = MAX_GAP_RESET;
      head = 0;
      fill = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_MAX_GAP)
        gap_limit = pwdata;
      if (in_valid && in_ready)
        predict_item(kind, time_stamp, {ang_z, ang_y, ang_x, lin_z, lin_y, lin_x});
      if (out_valid && out_ready) begin
        results_seen++;
        got_vel = {out_ang_z, out_ang_y, out_ang_x, out_lin_z, out_lin_y, out_lin_x};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", '0, status);
        end else begin
          exp_r = expected_q[0];
          expected_q.delete(0);
          if (status !== exp_r.stat) report_mismatch("status", exp_r.stat, status);
          if (out_time !== exp_r.t) report_mismatch("out_time", exp_r.t, out_time);
          for (int a = 0; a < AXES; a++)
            if (got_vel[a] !== exp_r.vel[a])
              report_mismatch($sformatf("velocity axis %0d", a), exp_r.vel[a], got_vel[a]);
        end
      end
    end
    pending = expected_q.size();
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
    pending = 0;
  end
endmodule

// ----- tb/tb_velocity_time_sync_interp_core.sv -----
// Top of the testbench for the velocity time-sync interpolation core.
// Drives items and register writes; relies on vtsi_checker and vtsi_pkg.
module tb_velocity_time_sync_interp_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vtsi_pkg::*;

  localparam int VW = 24;
  localparam int SETTLE_CYCLES = 500;

  logic clk, rst;
  logic in_valid, in_ready, kind, out_valid, out_ready;
  logic [TIME_W-1:0] time_stamp, out_time;
  logic signed [VW-1:0] lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;
  logic signed [VW-1:0] out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z;
  logic [STAT_W-1:0] status;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int fail_count, pending, results_seen;
  int items_sent, syncs_sent, settings_used;
  bit quiet, hold_req;
  logic [TIME_W-1:0] now_us;

  velocity_time_sync_interp_core #(.BUFFER_DEPTH(16), .VELOCITY_WIDTH(VW)) dut (.*);

  vtsi_checker #(.DEPTH(16), .VW(VW)) chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results still expected.", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (2000) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_max_gap(logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {REG_MAX_GAP, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    settings_used++;
  endtask

  // Offer one item, with an optional idle burst first; returns once accepted.
  task automatic send_item(logic k, logic [TIME_W-1:0] t, logic [AXES-1:0][VW-1:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k; time_stamp <= t;
    {ang_z, ang_y, ang_x, lin_z, lin_y, lin_x} <= v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (k == KIND_SYNC) syncs_sent++;
  endtask

  function automatic logic [AXES-1:0][VW-1:0] all_axes(logic [VW-1:0] x);
    return {AXES{x}};
  endfunction

  function automatic logic [AXES-1:0][VW-1:0] random_vel();
    logic [AXES-1:0][VW-1:0] v;
    for (int a = 0; a < AXES; a++) begin
      case ($urandom_range(0, 7))
        0: v[a] = {1'b0, {(VW-1){1'b1}}};
        1: v[a] = {1'b1, {(VW-1){1'b0}}};
        default: v[a] = VW'($urandom);
      endcase
    end
    return v;
  endfunction

  // Let the block drain completely before touching the register.
  task automatic wait_idle();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly time-ordered pushes with requests near the newest sample, some noise.
  task automatic random_phase(int count, int step, int quiet_from);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i == quiet_from) quiet = 1;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 9) != 0) now_us += $urandom_range(0, step);
        send_item(KIND_PUSH, now_us, random_vel());
      end else if (pick < 90) begin
        send_item(KIND_SYNC, now_us - $urandom_range(0, 3 * step), random_vel());
      end else if (pick < 95) begin
        send_item(1'($urandom_range(0, 1)), $urandom, random_vel());
      end else begin
        send_item(KIND_SYNC, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, random_vel());
      end
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0; kind = KIND_PUSH; time_stamp = '0;
    {lin_x, lin_y, lin_z, ang_x, ang_y, ang_z} = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    quiet = 0; hold_req = 0;
    items_sent = 0; syncs_sent = 0; settings_used = 0;
    now_us = 32'd5_000_000;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty ring, equal neighbor times, not-ready, gap drops,
    // extrapolation after a gap drop with saturation, time extremes.
    write_max_gap(MAX_GAP_RESET);
    send_item(KIND_SYNC, 32'd1000, '0);
    send_item(KIND_PUSH, 32'd1000, all_axes({1'b0, {(VW-1){1'b1}}}));
    send_item(KIND_SYNC, 32'd1000, '0);
    send_item(KIND_PUSH, 32'd1000, all_axes({1'b1, {(VW-1){1'b0}}}));
    send_item(KIND_SYNC, 32'd1000, '0);
    send_item(KIND_PUSH, 32'd3000, all_axes({1'b0, {(VW-1){1'b1}}}));
    send_item(KIND_SYNC, 32'd2000, '0);
    send_item(KIND_SYNC, 32'd500, '0);
    send_item(KIND_PUSH, 32'd1_000_000, random_vel());
    send_item(KIND_SYNC, 32'd900_000, '0);
    send_item(KIND_PUSH, 32'd1_200_000, random_vel());
    send_item(KIND_PUSH, 32'd1_250_000, random_vel());
    send_item(KIND_SYNC, 32'd1_150_000, '0);
    send_item(KIND_PUSH, 32'd1_600_000, random_vel());
    send_item(KIND_PUSH, 32'd1_610_000, random_vel());
    send_item(KIND_PUSH, 32'd2_000_000, all_axes({1'b1, {(VW-1){1'b0}}}));
    send_item(KIND_PUSH, 32'd2_000_001, all_axes({1'b0, {(VW-1){1'b1}}}));
    send_item(KIND_SYNC, 32'd1_900_000, '0);
    send_item(KIND_PUSH, 32'hFFFF_FFFF, random_vel());
    send_item(KIND_SYNC, 32'hFFFF_FFFF, '0);
    send_item(KIND_SYNC, 32'h0, '0);

    // Random phases under several gap limits, extremes included.
    wait_idle();
    write_max_gap(32'd0);
    random_phase(70, 20, -1);
    wait_idle();
    write_max_gap(32'hFFFF_FFFF);
    hold_req = 1;
    random_phase(80, 100_000, -1);
    wait_idle();
    write_max_gap($urandom_range(1000, 400_000));
    random_phase(80, 150_000, -1);
    wait_idle();
    write_max_gap(32'd50_000);
    random_phase(80, 30_000, -1);
    wait_idle();
    write_max_gap(MAX_GAP_RESET);
    random_phase(80, 80_000, 40);
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d sync requests) under %0d gap limit settings.",
             items_sent, syncs_sent, settings_used);
    $display("Checked %0d results; %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
